// ===== design/isl_pkg.sv =====
// Package for the indexed sequence list block.
// Holds the command, status and cell operation codes shared by the modules.
// No dependencies.
package isl_pkg;

  localparam int CMD_W   = 4;
  localparam int POS_W   = 9;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 9;

  // Input item packing (lowest bit first): command, position, item_value.
  localparam int IN_CMD_LO  = 0;
  localparam int IN_POS_LO  = IN_CMD_LO + CMD_W;
  localparam int IN_VAL_LO  = IN_POS_LO + POS_W;
  localparam int IN_DATA_W  = 48;

  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - (STAT_W + 1 + VAL_W + COUNT_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FRONT = 4'd0,
    CMD_ADD_BACK  = 4'd1,
    CMD_ADD_AT    = 4'd2,
    CMD_REM_FRONT = 4'd3,
    CMD_REM_BACK  = 4'd4,
    CMD_REM_AT    = 4'd5,
    CMD_FIND      = 4'd6,
    CMD_GET       = 4'd7,
    CMD_CLEAR     = 4'd8
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_INS  = 3'd1,
    OP_DEL  = 3'd2,
    OP_FIND = 3'd3,
    OP_GET  = 3'd4
  } cell_op_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t          op;
    logic [VAL_W-1:0]  key;
  } cell_cmd_t;

endpackage

// ===== design/isl_cell.sv =====
// One storage cell of the list chain: holds one entry and trades it with
// its neighbors on insert and remove. Depends on isl_pkg.
module isl_cell
  import isl_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 8,
  parameter int CW  = 9
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IW-1:0]     at,
  input  logic [CW-1:0]     cnt,
  input  logic [VAL_W-1:0]  left_value,
  input  logic [VAL_W-1:0]  right_value,
  output logic [VAL_W-1:0]  value,
  output logic              hit,
  output logic [VAL_W-1:0]  rd
);

  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] value_nxt;
  logic             above_at;
  logic             at_here;

  assign above_at = IW'(IDX) > at;
  assign at_here  = IW'(IDX) == at;

  always_comb begin
    value_nxt = value_r;
    case (cmd.op)
      OP_INS: begin
        if (above_at) value_nxt = left_value;
        else if (at_here) value_nxt = cmd.key;
      end
      OP_DEL: begin
        if (above_at || at_here) value_nxt = right_value;
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  // Only entries below the count take part in a search.
  assign hit   = (cmd.op == OP_FIND) && (CW'(IDX) < cnt) && (value_r == cmd.key);
  assign rd    = ((cmd.op == OP_GET) && at_here) ? value_r : '0;

endmodule

// ===== design/isl_or_tree.sv =====
// Two-level registered OR reduction of the cells' hit flags and read data.
// The first level is captured in groups; the second combines the groups.
// Depends on isl_pkg.
module isl_or_tree
  import isl_pkg::*;
#(
  parameter int N = 256
) (
  input  logic                 clk,
  input  logic                 capture,
  input  logic [N-1:0]         hit,
  input  logic [VAL_W-1:0]     rd [N],
  output logic                 found,
  output logic [VAL_W-1:0]     read_value
);

  localparam int GS = 16;
  localparam int NG = (N + GS - 1) / GS;

  logic             grp_hit_r [NG];
  logic [VAL_W-1:0] grp_rd_r  [NG];
  logic             grp_hit_nxt [NG];
  logic [VAL_W-1:0] grp_rd_nxt  [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_nxt[g] = 1'b0;
      grp_rd_nxt[g]  = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < N) begin
          grp_hit_nxt[g] = grp_hit_nxt[g] | hit[g * GS + k];
          grp_rd_nxt[g]  = grp_rd_nxt[g] | rd[g * GS + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int g = 0; g < NG; g++) begin
        grp_hit_r[g] <= grp_hit_nxt[g];
        grp_rd_r[g]  <= grp_rd_nxt[g];
      end
    end
  end

  always_comb begin
    found      = 1'b0;
    read_value = '0;
    for (int g = 0; g < NG; g++) begin
      found      = found | grp_hit_r[g];
      read_value = read_value | grp_rd_r[g];
    end
  end

endmodule

// ===== design/indexed_sequence_list.sv =====
// Indexed sequence list: an ordered list of up to CAPACITY signed 32-bit entries.
// Steps: accept in the idle state; shift/compare in the cell chain and group
// capture in the execute state; final reduction into the output register in the
// reduce state. A new command is taken once the last result is loaded; the input
// is free while that result waits at the output register. Reset (rst_n low,
// synchronous) empties the list; entry contents are kept and never read stale.
module indexed_sequence_list
  import isl_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [3:0] command, [12:4] position, [44:13] item_value, [47:45] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status, [2] found, [34:3] read_value, [43:35] count, [47:44] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Index width for a cell, count width able to hold CAPACITY itself, and a
  // compare width that covers both the count and the 9-bit position field.
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RED
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r;
  cell_op_t          op_r;
  logic [IW-1:0]     at_r;
  logic [VAL_W-1:0]  key_r;
  status_t           status_r;

  cell_op_t          op_nxt;
  logic [IW-1:0]     at_nxt;
  status_t           status_nxt;
  logic [CW-1:0]     cnt_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic              out_found_r;
  logic [VAL_W-1:0]  out_rd_r;
  logic [COUNT_W-1:0] out_count_r;

  logic              in_accept;
  logic              out_load;
  cmd_t              cmd;
  logic [POS_W-1:0]  pos;
  logic [WW-1:0]     pos_w;
  logic [WW-1:0]     cnt_w;
  logic              full;
  logic              empty;

  cell_cmd_t         cell_cmd;
  logic [VAL_W-1:0]  cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic [VAL_W-1:0]  cell_rd    [CAPACITY];
  logic              tree_found;
  logic [VAL_W-1:0]  tree_rd;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign cmd   = cmd_t'(in_tdata[IN_CMD_LO +: CMD_W]);
  assign pos   = in_tdata[IN_POS_LO +: POS_W];
  assign pos_w = WW'(pos);
  assign cnt_w = WW'(cnt_r);
  assign full  = (cnt_w == WW'(CAPACITY));
  assign empty = (cnt_r == '0);

  // Command decode: bounds checks, new count and the operation the cell chain
  // performs in the next cycle. A rejected command leaves the chain idle.
  always_comb begin
    op_nxt     = OP_NOP;
    at_nxt     = '0;
    status_nxt = ST_OK;
    cnt_nxt    = cnt_r;
    case (cmd)
      CMD_ADD_FRONT, CMD_ADD_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op_nxt  = OP_INS;
          at_nxt  = (cmd == CMD_ADD_FRONT) ? '0 : cnt_w[IW-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      CMD_ADD_AT: begin
        // The index check comes before the full check.
        if (pos_w > cnt_w) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op_nxt  = OP_INS;
          at_nxt  = pos_w[IW-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      CMD_REM_FRONT, CMD_REM_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          op_nxt  = OP_DEL;
          at_nxt  = (cmd == CMD_REM_FRONT) ? '0 : IW'(cnt_w - WW'(1));
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      CMD_REM_AT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_nxt = ST_RANGE;
        end else begin
          op_nxt  = OP_DEL;
          at_nxt  = pos_w[IW-1:0];
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      CMD_FIND: begin
        op_nxt = OP_FIND;
      end
      CMD_GET: begin
        if (pos_w >= cnt_w) begin
          status_nxt = ST_RANGE;
        end else begin
          op_nxt = OP_GET;
          at_nxt = pos_w[IW-1:0];
        end
      end
      CMD_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        // Unused command codes change nothing and report ok.
        op_nxt = OP_NOP;
      end
    endcase
  end

  assign out_load = (state_r == S_RED) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            cnt_r   <= cnt_nxt;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_RED;
        end
        S_RED: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= op_nxt;
      at_r     <= at_nxt;
      key_r    <= in_tdata[IN_VAL_LO +: VAL_W];
      status_r <= status_nxt;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_found_r  <= tree_found;
      out_rd_r     <= tree_rd;
      out_count_r  <= cnt_w[COUNT_W-1:0];
    end
  end

  // The chain acts only in the execute cycle.
  assign cell_cmd.op  = (state_r == S_EXEC) ? op_r : OP_NOP;
  assign cell_cmd.key = key_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end
    isl_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .at          (at_r),
      .cnt         (cnt_r),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i]),
      .hit         (cell_hit[i]),
      .rd          (cell_rd[i])
    );
  end

  isl_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk        (clk),
    .capture    (state_r == S_EXEC),
    .hit        (cell_hit),
    .rd         (cell_rd),
    .found      (tree_found),
    .read_value (tree_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_count_r, out_rd_r, out_found_r, out_status_r};

endmodule

// ===== design/isl_checker.sv =====
// Port-level checker for the indexed sequence list, bound to the top level.
// Depends on isl_pkg and on the ports of indexed_sequence_list.
module isl_checker
  import isl_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The block works on one command at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a command is in flight");

  // The reported count never exceeds the capacity (checked for capacities up to 511).
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CAPACITY > 511) || (out_tdata[43:35] <= CAPACITY))
    else $error("count above capacity");

  // A search hit and read data come only with an ok status, never together.
  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2] || out_tdata[34:3] != '0)
      |-> out_tdata[1:0] == ST_OK && !(out_tdata[2] && out_tdata[34:3] != '0))
    else $error("found or read data with a failing status");

endmodule

bind indexed_sequence_list isl_checker #(.CAPACITY(CAPACITY)) u_isl_checker (.*);
